// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the port checker module.
// Needs nothing beyond the simulator's assertion support.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on the rising edge, ignored while reset is active.
`define MSTC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mstc check failed");

// Property checked on every rising edge, reset included.
`define MSTC_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("mstc reset check failed");

`endif

// ===== hw/rtl/mstc_pkg.sv =====
// Types, constants and table functions of the millisecond calendar clock.
// Stands alone; used by every other file of the block but assert_macros.svh.
`timescale 1ns / 1ps

package mstc_pkg;

    localparam int unsigned CntW   = 32;
    localparam int unsigned OfsW   = 37;
    localparam int unsigned RemW   = 36;
    localparam int unsigned QuotW  = 26;
    localparam int unsigned StepW  = 5;
    localparam int unsigned CfgIdxW = 2;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_SET   = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    localparam logic [CfgIdxW-1:0] REG_START_OFS = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_EPOCH     = 2'd1;

    // Last divider step of each quotient field: day, hour, minute, second.
    localparam logic [StepW-1:0] DAY_LAST  = 5'd8;
    localparam logic [StepW-1:0] HOUR_LAST = 5'd13;
    localparam logic [StepW-1:0] MIN_LAST  = 5'd19;
    localparam logic [StepW-1:0] SEC_LAST  = 5'd25;

    localparam logic [RemW-1:0] DIV_DAY  = 36'd86400000;
    localparam logic [RemW-1:0] DIV_HOUR = 36'd3600000;
    localparam logic [RemW-1:0] DIV_MIN  = 36'd60000;
    localparam logic [RemW-1:0] DIV_SEC  = 36'd1000;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] set_year;
        logic [3:0]  set_month;
        logic [4:0]  set_day;
        logic [4:0]  set_hour;
        logic [5:0]  set_minute;
        logic [5:0]  set_second;
    } t_in_item;

    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [8:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [31:0] ms_count;
        logic [31:0] epoch;
    } t_out_item;

    // Day of year at which month m starts, zero based; zero for codes outside 1..12.
    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] m);
        logic [8:0] base;
        unique case (m)
            4'd1:    base = 9'd0;
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        return base + {8'd0, (leap && (m >= 4'd3) && (m <= 4'd12))};
    endfunction

    // Milliseconds per unit of each set field: day, hour, minute, second.
    function automatic logic [26:0] term_mult(input logic [1:0] k);
        logic [26:0] r;
        unique case (k)
            2'd0: r = 27'd86400000;
            2'd1: r = 27'd3600000;
            2'd2: r = 27'd60000;
            2'd3: r = 27'd1000;
        endcase
        return r;
    endfunction

    // Shifted divisor tried at each step of the restoring divider.
    function automatic logic [RemW-1:0] div_sub(input logic [StepW-1:0] step);
        logic [RemW-1:0] r;
        priority if (step <= DAY_LAST)  r = DIV_DAY  << (DAY_LAST - step);
        else if (step <= HOUR_LAST)     r = DIV_HOUR << (HOUR_LAST - step);
        else if (step <= MIN_LAST)      r = DIV_MIN  << (MIN_LAST - step);
        else if (step <= SEC_LAST)      r = DIV_SEC  << (SEC_LAST - step);
        else                            r = '0;
        return r;
    endfunction

endpackage

// ===== hw/rtl/mstc_div.sv =====
// Bit-serial restoring divider: splits a millisecond count into day, hour,
// minute and second, one quotient bit per cycle. Depends on mstc_pkg.
`timescale 1ns / 1ps

module mstc_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [mstc_pkg::RemW-1:0]      i_dividend,
    output logic                           o_done,
    output logic [mstc_pkg::QuotW-1:0]     o_quot
);

    logic                          r_busy;
    logic                          r_done;
    logic [mstc_pkg::StepW-1:0]    r_step;
    logic [mstc_pkg::RemW-1:0]     r_rem;
    logic [mstc_pkg::QuotW-1:0]    r_quot;
    logic [mstc_pkg::RemW:0]       w_diff;
    logic                          w_take;

    assign w_diff = {1'b0, r_rem} - {1'b0, mstc_pkg::div_sub(r_step)};
    assign w_take = !w_diff[mstc_pkg::RemW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_step == mstc_pkg::SEC_LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == mstc_pkg::SEC_LAST) begin
                    r_busy <= 1'b0;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

    // Remainder carries over from one field to the next.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
        end else if (r_busy) begin
            if (w_take) begin
                r_rem <= w_diff[mstc_pkg::RemW-1:0];
            end
            r_quot <= {r_quot[mstc_pkg::QuotW-2:0], w_take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== hw/rtl/ms_tick_calendar_clock_top.sv =====
// Millisecond calendar clock: tick counter, calendar set and time readout.
// Items pass S_LOAD, the 26-step bit-serial divider (S_DIV) and S_FIN; set items
// first run the serial year check and field sum. With the year unset the divider
// is skipped. The next item is taken in the same cycle that the result is shown.
// Reset (synchronous, active low): counter, epoch and year cleared, time unset.
`timescale 1ns / 1ps

module ms_tick_calendar_clock_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  mstc_pkg::t_in_item                  i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output mstc_pkg::t_out_item                 o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mstc_pkg::CfgIdxW-1:0]        i_cfg_index,
    input  logic [31:0]                         i_cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LEAP = 6'b000010,
        S_SUM  = 6'b000100,
        S_LOAD = 6'b001000,
        S_DIV  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state                          r_state;
    logic [mstc_pkg::CntW-1:0]       r_cnt;
    logic [31:0]                     r_epoch;
    logic [15:0]                     r_year;
    logic                            r_leap;
    logic signed [mstc_pkg::OfsW-1:0] r_ofs;
    mstc_pkg::t_in_item              r_item;
    logic [15:0]                     r_y_sh;
    logic [4:0]                      r_mod25;
    logic [3:0]                      r_bitcnt;
    mstc_pkg::t_out_item             r_out;
    logic                            r_out_valid;

    logic                            w_accept;
    logic                            w_out_free;
    logic [5:0]                      w_mod_v;
    logic [4:0]                      w_mod_n;
    logic                            w_leap_set;
    logic [8:0]                      w_op;
    logic [35:0]                     w_prod;
    logic signed [mstc_pkg::OfsW-1:0] w_total;
    logic [mstc_pkg::RemW-1:0]       w_t;
    logic                            w_div_start;
    logic                            w_div_done;
    logic [mstc_pkg::QuotW-1:0]      w_quot;
    logic [8:0]                      w_day;
    logic [3:0]                      w_mon;
    mstc_pkg::t_out_item             w_res;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Serial remainder of the year by 25, fed MSB first.
    assign w_mod_v = {r_mod25, r_y_sh[15]};
    assign w_mod_n = (w_mod_v >= 6'd25) ? 5'(w_mod_v - 6'd25) : w_mod_v[4:0];

    // Leap: divisible by 4 and not by 25, or by 16 and by 25.
    assign w_leap_set = ((r_item.set_year[1:0] == 2'd0) && (r_mod25 != 5'd0)) ||
                        ((r_item.set_year[3:0] == 4'd0) && (r_mod25 == 5'd0));

    always_comb begin
        unique case (r_bitcnt[1:0])
            2'd0: w_op = {4'd0, r_item.set_day} +
                         mstc_pkg::month_start(w_leap_set, r_item.set_month);
            2'd1: w_op = {4'd0, r_item.set_hour};
            2'd2: w_op = {3'd0, r_item.set_minute};
            2'd3: w_op = {3'd0, r_item.set_second};
        endcase
    end

    assign w_prod = w_op * mstc_pkg::term_mult(r_bitcnt[1:0]);

    // Clamp a time before year start to zero.
    assign w_total     = r_ofs + $signed({5'd0, r_cnt});
    assign w_t         = w_total[mstc_pkg::OfsW-1] ? '0 : w_total[mstc_pkg::RemW-1:0];
    assign w_div_start = (r_state == S_LOAD) && (r_year != 16'd0);

    mstc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_t),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_comb begin
        w_day = w_quot[25:17];
        w_mon = 4'd1;
        for (int k = 2; k <= 12; k++) begin
            if (mstc_pkg::month_start(r_leap, 4'(k)) <= w_day) begin
                w_mon = w_mon + 4'd1;
            end
        end
        w_res          = '0;
        w_res.year     = r_year;
        w_res.ms_count = r_cnt;
        w_res.epoch    = r_epoch;
        if (r_year != 16'd0) begin
            w_res.month        = w_mon;
            w_res.day_of_month = w_day - mstc_pkg::month_start(r_leap, w_mon);
            w_res.hour         = w_quot[16:12];
            w_res.minute       = w_quot[11:6];
            w_res.second       = w_quot[5:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_epoch     <= '0;
            r_year      <= '0;
            r_leap      <= 1'b0;
            r_ofs       <= '0;
            r_out_valid <= 1'b0;
            r_bitcnt    <= '0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == mstc_pkg::REG_START_OFS) begin
                    r_cnt <= i_cfg_data;
                end else if (i_cfg_index == mstc_pkg::REG_EPOCH) begin
                    r_epoch <= i_cfg_data;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_bitcnt <= '0;
                        if (i_in.mode == mstc_pkg::MODE_TICK) begin
                            r_cnt   <= r_cnt + 1'b1;
                            r_state <= S_LOAD;
                        end else if (i_in.mode == mstc_pkg::MODE_SET) begin
                            r_ofs   <= -$signed({5'd0, r_cnt});
                            r_state <= S_LEAP;
                        end else begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_LEAP: begin
                    r_bitcnt <= r_bitcnt + 1'b1;
                    if (r_bitcnt == 4'd15) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_ofs    <= r_ofs + $signed({1'b0, w_prod});
                    r_bitcnt <= r_bitcnt + 1'b1;
                    if (r_bitcnt[1:0] == 2'd3) begin
                        r_year  <= r_item.set_year;
                        r_leap  <= w_leap_set;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_state <= (r_year != 16'd0) ? S_DIV : S_FIN;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Item capture, year shift line and result register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item  <= i_in;
            r_y_sh  <= i_in.set_year;
            r_mod25 <= '0;
        end else if (r_state == S_LEAP) begin
            r_y_sh  <= {r_y_sh[14:0], 1'b0};
            r_mod25 <= w_mod_n;
        end
        if ((r_state == S_FIN) && w_out_free) begin
            r_out <= w_res;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== hw/rtl/mstc_chk.sv =====
// Port checker of the millisecond calendar clock, bound to the top level.
// Depends on mstc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mstc_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input mstc_pkg::t_out_item           o_out
);

    logic w_cal_zero;
    logic w_cal_range;

    assign w_cal_zero  = (o_out.month == 4'd0) && (o_out.day_of_month == 9'd0) &&
                         (o_out.hour == 5'd0) && (o_out.minute == 6'd0) &&
                         (o_out.second == 6'd0);
    assign w_cal_range = (o_out.month >= 4'd1) && (o_out.month <= 4'd12) &&
                         (o_out.hour < 5'd24) && (o_out.minute < 6'd60) &&
                         (o_out.second < 6'd60);

    // A waiting result holds until taken.
    `MSTC_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid)

    // No result right after reset.
    `MSTC_ASSERT_RST(a_rst_empty, i_clk, !i_rst_n |=> !o_out_valid)

    // Unset time reads month, day, hour, minute and second as zero.
    `MSTC_ASSERT(a_unset_zero, i_clk, i_rst_n, o_out_valid && (o_out.year == 16'd0) |-> w_cal_zero)

    // Set time stays in its calendar ranges.
    `MSTC_ASSERT(a_set_range, i_clk, i_rst_n, o_out_valid && (o_out.year != 16'd0) |-> w_cal_range)

    // The next item is held off once one is taken.
    `MSTC_ASSERT(a_in_one, i_clk, i_rst_n, i_in_valid && o_in_ready |=> !o_in_ready)

endmodule

bind ms_tick_calendar_clock_top mstc_chk u_mstc_chk (.*);
